### src/wheel_odometry_update_assert.svh
// ----------------------------------------------------------------------------
// wheel odometry update assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WHEEL_ODOMETRY_UPDATE_ASSERT_SVH
`define WHEEL_ODOMETRY_UPDATE_ASSERT_SVH

// same-cycle implication, off during reset
`define WOU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define WOU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define WOU_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/wou_pkg.sv
// ----------------------------------------------------------------------------
// wou_pkg
// shared types, constants and fixed point helpers for wheel odometry update
// ----------------------------------------------------------------------------
package wou_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 32;
  localparam int STEP_CNT_W       = $clog2(MAX_STEPS + 1);
  localparam int DIV_W            = 64;
  localparam int DIV_CNT_W        = $clog2(DIV_W + 1);

  // divide by 45 in 16-bit digits: floor(v * recip / 2^28) is exact for v < 2^22
  localparam int          DIV45_STEPS = 4;
  localparam logic [22:0] DIV45_RECIP = 23'd5965233;

  localparam int HALF_TURN    = 46080;
  localparam int FULL_TURN    = 92160;
  localparam int QUARTER_TURN = 23040;
  localparam int TURN_MIN     = 15;

  // 1/256 degree to q30 radian, scaled by 2^16
  localparam logic [32:0] DEG_TO_Q30 = 33'd4797524517;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh26DD3B6A;

  typedef enum logic [1:0] {
    MODE_STATIONARY = 2'd0,
    MODE_TURNING    = 2'd1,
    MODE_STRAIGHT   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MOTION_MODE    = 2'd0,
    REG_LATERAL_ENABLE = 2'd1,
    REG_WHEEL_CIRC     = 2'd2
  } reg_idx_t;

  // one classified sample handed from front to back
  typedef struct packed {
    mode_t              mode;
    logic [19:0]        circ;
    logic signed [33:0] dsum;
    logic signed [32:0] dlat;
    logic signed [16:0] dh;
    logic signed [16:0] head;
  } cmd_t;

  // map into [-half turn, half turn) for inputs within three full turns
  function automatic logic signed [16:0] wrap_heading(input logic signed [20:0] a);
    logic signed [20:0] t;
    logic signed [16:0] res;
    res = '0;
    for (int k = -3; k <= 3; k++) begin
      t = a - 21'(k * FULL_TURN);
      if (t >= 21'(-HALF_TURN) && t < 21'(HALF_TURN)) begin
        res = t[16:0];
      end
    end
    return res;
  endfunction

  // heading units to q30 radians, rounded half away from zero
  function automatic logic signed [34:0] to_q30(input logic signed [16:0] a);
    logic [16:0] m;
    logic [49:0] p;
    logic [33:0] r;
    m = a[16] ? (~a + 17'd1) : a;
    p = 50'(m) * 50'(DEG_TO_Q30);
    r = 34'((p + 50'd32768) >> 16);
    return a[16] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### src/wheel_odometry_update.sv
// ----------------------------------------------------------------------------
// wheel_odometry_update
// dead reckoning pose update from tracking wheels and inertial heading
// stationary: mean divide only; straight: mean divide, cordic, x and y multiplies
//   large turns: mean and lateral divides, two cordic passes, arc divide, y multiply
// one word at a time in the back end; a two-word queue takes new samples meanwhile
// reset (sync, active low) clears pose, last sample and config to defaults
// ----------------------------------------------------------------------------
module wheel_odometry_update #(
  parameter int CORDIC_STEPS = wou_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_left_angle,
  input  logic signed [31:0] in_right_angle,
  input  logic signed [31:0] in_lateral_angle,
  input  logic signed [17:0] in_heading_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_pos_x,
  output logic signed [39:0] out_pos_y,
  output logic signed [16:0] out_heading_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int CMD_W = $bits(wou_pkg::cmd_t);

  logic [1:0]    motion_mode_r;
  logic          lateral_enable_r;
  logic [19:0]   wheel_circ_r;
  logic          q_full, q_push, q_empty, q_pop;
  wou_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_mode_r    <= wou_pkg::MODE_STATIONARY;
      lateral_enable_r <= 1'b1;
      wheel_circ_r     <= 20'd8192;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wou_pkg::REG_MOTION_MODE:    motion_mode_r    <= cfg_data[1:0];
        wou_pkg::REG_LATERAL_ENABLE: lateral_enable_r <= cfg_data[0];
        wou_pkg::REG_WHEEL_CIRC:     wheel_circ_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  wou_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_left_angle       (in_left_angle),
    .in_right_angle      (in_right_angle),
    .in_lateral_angle    (in_lateral_angle),
    .in_heading_now      (in_heading_now),
    .motion_mode         (motion_mode_r),
    .lateral_enable      (lateral_enable_r),
    .wheel_circumference (wheel_circ_r),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (push_cmd)
  );

  wou_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (pop_cmd)
  );

  wou_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading_out (out_heading_out)
  );

endmodule

### src/wou_front.sv
// ----------------------------------------------------------------------------
// wou_front
// takes samples, forms encoder and heading deltas, keeps the last sample
// ----------------------------------------------------------------------------
module wou_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_left_angle,
  input  logic signed [31:0]  in_right_angle,
  input  logic signed [31:0]  in_lateral_angle,
  input  logic signed [17:0]  in_heading_now,
  input  logic [1:0]          motion_mode,
  input  logic                lateral_enable,
  input  logic [19:0]         wheel_circumference,
  input  logic                q_full,
  output logic                q_push,
  output wou_pkg::cmd_t       q_cmd
);

  logic signed [31:0] last_left_r, last_right_r, last_lateral_r;
  logic signed [17:0] last_heading_r;
  logic signed [31:0] lat_sel;
  logic signed [32:0] dl, dr;
  logic signed [20:0] dh_raw;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    lat_sel = lateral_enable ? in_lateral_angle : last_lateral_r;
    dl      = 33'(in_left_angle) - 33'(last_left_r);
    dr      = 33'(in_right_angle) - 33'(last_right_r);
    dh_raw  = 21'(in_heading_now) - 21'(last_heading_r);
    q_cmd.mode = wou_pkg::mode_t'(motion_mode);
    q_cmd.circ = wheel_circumference;
    q_cmd.dsum = 34'(dl) + 34'(dr);
    q_cmd.dlat = 33'(lat_sel) - 33'(last_lateral_r);
    q_cmd.dh   = wou_pkg::wrap_heading(dh_raw);
    q_cmd.head = wou_pkg::wrap_heading(21'(in_heading_now));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r    <= '0;
      last_right_r   <= '0;
      last_lateral_r <= '0;
      last_heading_r <= '0;
    end else if (q_push) begin
      last_left_r    <= in_left_angle;
      last_right_r   <= in_right_angle;
      last_lateral_r <= lat_sel;
      last_heading_r <= in_heading_now;
    end
  end

endmodule

### src/wou_queue.sv
// ----------------------------------------------------------------------------
// wou_queue
// two-word queue between front and back
// ----------------------------------------------------------------------------
module wou_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/wou_cordic.sv
// ----------------------------------------------------------------------------
// wou_cordic
// iterative rotation cordic, one step per cycle, gives cos and sin in q30
// ----------------------------------------------------------------------------
module wou_cordic #(
  parameter int CORDIC_STEPS = wou_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [34:0] z0,
  input  logic               neg,
  output logic               busy,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_r, y_r;
  logic signed [34:0] z_r;
  logic [wou_pkg::STEP_CNT_W-1:0] i_r;
  logic busy_r, neg_r;
  logic signed [34:0] at;
  logic signed [33:0] x_sh, y_sh;

  assign busy  = busy_r;
  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;

  always_comb begin
    at   = $signed({3'b000, wou_pkg::atan_q30(i_r[4:0])});
    x_sh = x_r >>> i_r[4:0];
    y_sh = y_r >>> i_r[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && i_r == wou_pkg::STEP_CNT_W'(CORDIC_STEPS - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= wou_pkg::CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z0;
      i_r   <= '0;
      neg_r <= neg;
    end else if (busy_r) begin
      // rotate toward zero residual angle
      if (!z_r[34]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + at;
      end
      i_r <= i_r + 1'b1;
    end
  end

endmodule

### src/wou_back.sv
// ----------------------------------------------------------------------------
// wou_back
// pose update sequencer: shared divider, multiplier and cordic, pose state
// ----------------------------------------------------------------------------
module wou_back #(
  parameter int CORDIC_STEPS = wou_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wou_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_pos_x,
  output logic signed [39:0] out_pos_y,
  output logic signed [16:0] out_heading_out
);

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_AVG        = 16'h0002,
    S_AVG_DIV    = 16'h0004,
    S_LAT        = 16'h0008,
    S_LAT_DIV    = 16'h0010,
    S_TRIG0      = 16'h0020,
    S_TRIG0_WAIT = 16'h0040,
    S_TRIG1      = 16'h0080,
    S_TRIG1_WAIT = 16'h0100,
    S_Q          = 16'h0200,
    S_Q_DIV      = 16'h0400,
    S_MX_LO      = 16'h0800,
    S_MX_HI      = 16'h1000,
    S_MY_LO      = 16'h2000,
    S_MY_HI      = 16'h4000,
    S_FIN        = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  wou_pkg::cmd_t cmd_r;

  logic [43:0]        avg_mag_r;
  logic               avg_neg_r;
  logic signed [33:0] c0_r, s0_r;
  logic [31:0]        q_mag_r;
  logic               q_neg_r;
  logic [39:0]        dx_r, dy_r;
  logic [63:0]        plo_r;
  logic signed [39:0] x_acc_r, y_acc_r;
  logic signed [16:0] pose_r;
  logic               out_valid_r;

  // shared divider: restoring, one quotient bit per cycle, or by 45 a digit per cycle
  logic [63:0] div_num_r;
  logic [34:0] div_rem_r;
  logic [33:0] div_den_r;
  logic [wou_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic        div_neg_r;
  logic        div_c45_r;
  logic        div_done, div_load, div_neg_ld, div_ge, div_c45_ld;
  logic [63:0] div_num_ld;
  logic [33:0] div_den_ld;
  logic [34:0] rem_sh;
  logic [21:0] c45_v;
  logic [44:0] c45_p;
  logic [15:0] c45_q;
  logic [5:0]  c45_rem;

  logic [33:0] dsum_mag, dist_mag;
  logic [32:0] dlat_mag;
  logic [53:0] dist_prod;
  logic        big_turn, fin_go, is_straight, in_mx;

  logic signed [16:0] ang, fold;
  logic               fold_neg;
  logic signed [34:0] z0;
  logic               cordic_start, cordic_busy;
  logic signed [33:0] cordic_cos, cordic_sin;

  logic signed [34:0] s_diff, drad;
  logic [32:0]        sd_mag;
  logic [33:0]        drad_mag, c0_mag, s0_mag;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [39:0] mul_mag, mul_res;
  logic        mul_neg;

  assign out_valid       = out_valid_r;
  assign out_pos_x       = x_acc_r;
  assign out_pos_y       = y_acc_r;
  assign out_heading_out = pose_r;

  assign div_done    = (div_cnt_r == '0);
  assign fin_go      = !out_valid_r || !out_stall;
  assign is_straight = (cmd_r.mode == wou_pkg::MODE_STRAIGHT);
  assign in_mx       = (state_r == S_MX_LO) || (state_r == S_MX_HI);
  assign big_turn    = (cmd_r.dh >= 17'(wou_pkg::TURN_MIN)) ||
                       (cmd_r.dh <= 17'(-wou_pkg::TURN_MIN));

  // distance products for mean and lateral travel
  always_comb begin
    dsum_mag  = cmd_r.dsum[33] ? 34'(-cmd_r.dsum) : 34'(cmd_r.dsum);
    dlat_mag  = cmd_r.dlat[32] ? 33'(-cmd_r.dlat) : 33'(cmd_r.dlat);
    dist_mag  = (state_r == S_LAT) ? 34'(dlat_mag) : dsum_mag;
    dist_prod = 54'(dist_mag) * 54'(cmd_r.circ);
  end

  // angle set-up: fold into +-90 degrees, negate results when folded
  always_comb begin
    ang = (state_r == S_TRIG1) ?
          wou_pkg::wrap_heading(21'(pose_r) + 21'(cmd_r.dh)) : pose_r;
    fold     = ang;
    fold_neg = 1'b0;
    if (ang > 17'(wou_pkg::QUARTER_TURN)) begin
      fold     = ang - 17'(wou_pkg::HALF_TURN);
      fold_neg = 1'b1;
    end else if (ang < 17'(-wou_pkg::QUARTER_TURN)) begin
      fold     = ang + 17'(wou_pkg::HALF_TURN);
      fold_neg = 1'b1;
    end
    z0 = wou_pkg::to_q30(fold);
  end

  // arc term operands
  always_comb begin
    s_diff   = 35'(cordic_sin) - 35'(s0_r);
    sd_mag   = s_diff[34] ? 33'(-s_diff) : 33'(s_diff);
    drad     = wou_pkg::to_q30(cmd_r.dh);
    drad_mag = drad[34] ? 34'(-drad) : 34'(drad);
  end

  // q30 multiply in two halves through one 32x32 multiplier
  always_comb begin
    c0_mag  = c0_r[33] ? 34'(-c0_r) : 34'(c0_r);
    s0_mag  = s0_r[33] ? 34'(-s0_r) : 34'(s0_r);
    if (in_mx) begin
      mul_b   = c0_mag[31:0];
      mul_neg = avg_neg_r ^ c0_r[33];
    end else if (is_straight) begin
      mul_b   = s0_mag[31:0];
      mul_neg = avg_neg_r ^ s0_r[33];
    end else begin
      mul_b   = q_mag_r;
      mul_neg = avg_neg_r ^ q_neg_r;
    end
    mul_a    = (state_r == S_MX_HI || state_r == S_MY_HI) ?
               {20'd0, avg_mag_r[43:32]} : avg_mag_r[31:0];
    mul_full = 64'(mul_a) * 64'(mul_b);
    mul_mag  = 40'({mul_full[43:0], 2'b00}) + 40'((plo_r + 64'd536870912) >> 30);
    mul_res  = mul_neg ? -mul_mag : mul_mag;
  end

  always_comb begin
    rem_sh = {div_rem_r[33:0], div_num_r[63]};
    div_ge = (rem_sh >= {1'b0, div_den_r});
  end

  // remainder below 45 keeps the digit dividend under 2^22
  always_comb begin
    c45_v   = {div_rem_r[5:0], div_num_r[63:48]};
    c45_p   = 45'(c45_v) * 45'(wou_pkg::DIV45_RECIP);
    c45_q   = c45_p[43:28];
    c45_rem = 6'(c45_v - 22'(c45_q) * 22'd45);
  end

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    div_load     = 1'b0;
    div_num_ld   = '0;
    div_den_ld   = '0;
    div_neg_ld   = 1'b0;
    div_c45_ld   = 1'b0;
    cordic_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        // divide by 720 as a shift by 4 then by 45
        div_load   = 1'b1;
        div_c45_ld = 1'b1;
        div_num_ld = (64'(dist_prod) + 64'd360) >> 4;
        div_neg_ld = cmd_r.dsum[33];
        state_nxt  = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (div_done) begin
          if (cmd_r.mode == wou_pkg::MODE_TURNING) begin
            state_nxt = big_turn ? S_LAT : S_FIN;
          end else if (is_straight) begin
            state_nxt = S_TRIG0;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_LAT: begin
        // divide by 360 as a shift by 3 then by 45
        div_load   = 1'b1;
        div_c45_ld = 1'b1;
        div_num_ld = (64'(dist_prod) + 64'd180) >> 3;
        div_neg_ld = cmd_r.dlat[32];
        state_nxt  = S_LAT_DIV;
      end
      S_LAT_DIV: begin
        if (div_done) begin
          state_nxt = S_TRIG0;
        end
      end
      S_TRIG0: begin
        cordic_start = 1'b1;
        state_nxt    = S_TRIG0_WAIT;
      end
      S_TRIG0_WAIT: begin
        if (!cordic_busy) begin
          state_nxt = is_straight ? S_MX_LO : S_TRIG1;
        end
      end
      S_TRIG1: begin
        cordic_start = 1'b1;
        state_nxt    = S_TRIG1_WAIT;
      end
      S_TRIG1_WAIT: begin
        if (!cordic_busy) begin
          state_nxt = S_Q;
        end
      end
      S_Q: begin
        div_load   = 1'b1;
        div_num_ld = {1'b0, sd_mag, 30'd0} + 64'(drad_mag >> 1);
        div_den_ld = drad_mag;
        div_neg_ld = s_diff[34] ^ drad[34];
        state_nxt  = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (div_done) begin
          state_nxt = S_MY_LO;
        end
      end
      S_MX_LO: state_nxt = S_MX_HI;
      S_MX_HI: state_nxt = S_MY_LO;
      S_MY_LO: state_nxt = S_MY_HI;
      S_MY_HI: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      pose_r      <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FIN && fin_go) begin
        x_acc_r     <= x_acc_r + $signed(dx_r);
        y_acc_r     <= y_acc_r + $signed(dy_r);
        pose_r      <= cmd_r.head;
        out_valid_r <= 1'b1;
      end
      if (div_load) begin
        div_cnt_r <= div_c45_ld ? wou_pkg::DIV_CNT_W'(wou_pkg::DIV45_STEPS) :
                                  wou_pkg::DIV_CNT_W'(wou_pkg::DIV_W);
      end else if (!div_done) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_num_r <= div_num_ld;
      div_den_r <= div_den_ld;
      div_rem_r <= '0;
      div_neg_r <= div_neg_ld;
      div_c45_r <= div_c45_ld;
    end else if (!div_done) begin
      if (div_c45_r) begin
        div_rem_r <= 35'(c45_rem);
        div_num_r <= {div_num_r[47:0], c45_q};
      end else begin
        div_rem_r <= div_ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;
        div_num_r <= {div_num_r[62:0], div_ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      dx_r  <= '0;
      dy_r  <= '0;
    end
    if (state_r == S_AVG_DIV && div_done) begin
      avg_mag_r <= div_num_r[43:0];
      avg_neg_r <= div_neg_r;
    end
    if (state_r == S_LAT_DIV && div_done) begin
      dx_r <= div_neg_r ? -div_num_r[39:0] : div_num_r[39:0];
    end
    if (state_r == S_TRIG0_WAIT && !cordic_busy) begin
      c0_r <= cordic_cos;
      s0_r <= cordic_sin;
    end
    if (state_r == S_Q_DIV && div_done) begin
      // clamp the arc radius to +-2^31
      q_mag_r <= (div_num_r > 64'h8000_0000) ? 32'h8000_0000 : div_num_r[31:0];
      q_neg_r <= div_neg_r;
    end
    if (state_r == S_MX_LO || state_r == S_MY_LO) begin
      plo_r <= mul_full;
    end
    if (state_r == S_MX_HI) begin
      dx_r <= mul_res;
    end
    if (state_r == S_MY_HI) begin
      dy_r <= mul_res;
    end
  end

  wou_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .z0    (z0),
    .neg   (fold_neg),
    .busy  (cordic_busy),
    .cos_o (cordic_cos),
    .sin_o (cordic_sin)
  );

endmodule

### src/wou_checker.sv
// ----------------------------------------------------------------------------
// wou_checker
// port-level checks for wheel odometry update, bound to the top level
// ----------------------------------------------------------------------------
`include "wheel_odometry_update_assert.svh"

module wou_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [39:0] out_pos_x,
  input logic signed [39:0] out_pos_y,
  input logic signed [16:0] out_heading_out
);

  `WOU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_heading_out), "result word changed while stalled")
  `WOU_ASSERT_IMP(a_heading_range, out_valid, (out_heading_out >= -17'sd46080) && (out_heading_out <= 17'sd46079), "heading out of range")
  `WOU_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && !in_stall, "block not idle after reset")

endmodule

bind wheel_odometry_update wou_checker u_wou_checker (.*);
